// ===== rtl/core/canfcm_pkg.sv =====
package canfcm_pkg;

  // table geometry
  localparam int CHANNELS = 16;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CNT_W = $clog2(CHANNELS + 1);

  // fixed field widths
  localparam int CIDX_W    = 4;
  localparam int ID_W      = 29;
  localparam int START_W   = 3;
  localparam int LEN_W     = 4;
  localparam int VAL_W     = 32;
  localparam int DATA_W    = 64;
  localparam int EN_W      = 5;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int MAX_BYTES = 4;

  // slave tdata layout, lowest bit first
  localparam int OFF_IDX   = 0;
  localparam int OFF_EID   = OFF_IDX + CIDX_W;
  localparam int OFF_EMSK  = OFF_EID + ID_W;
  localparam int OFF_BST   = OFF_EMSK + ID_W;
  localparam int OFF_BLEN  = OFF_BST + START_W;
  localparam int OFF_DMSK  = OFF_BLEN + LEN_W;
  localparam int OFF_MUL   = OFF_DMSK + VAL_W;
  localparam int OFF_DIV   = OFF_MUL + VAL_W;
  localparam int OFF_OFS   = OFF_DIV + VAL_W;
  localparam int OFF_FID   = OFF_OFS + VAL_W;
  localparam int OFF_FDAT  = OFF_FID + ID_W;
  localparam int S_USED_W  = OFF_FDAT + DATA_W;
  localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_NONE  = 2'd0,
    STAT_MATCH = 2'd1,
    STAT_BAD   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH,
    ST_RESULT
  } fsm_e;

  typedef struct packed {
    logic [ID_W-1:0]    match_id;
    logic [ID_W-1:0]    id_mask;
    logic [START_W-1:0] byte_start;
    logic [LEN_W-1:0]   byte_length;
    logic [VAL_W-1:0]   data_mask;
    logic [VAL_W-1:0]   multiplier;
    logic [VAL_W-1:0]   divisor;
    logic [VAL_W-1:0]   offset;
  } entry_t;

endpackage

// ===== rtl/core/can_frame_channel_mapper_core.sv =====
// channel   signals                                   fields (lsb first)
// s_axis    s_axis_tvalid_i/tready_o/tdata_i/tuser_i  tuser: command; tdata: see port
// m_axis    m_axis_tvalid_o/tready_i/tdata_o/tuser_o  tuser: status; tdata: value
// cfg       cfg_we_i/cfg_wdata_i                      enabled_channels
//
// load, read and unused commands pass through the result state before ready returns.
// frame: the walk visits the enabled entries; a matching entry passes through the multiply
// step and, with a nonzero divisor, the 32-step shared radix-2 divider.
// reset clears the stored channel values, the count register and all control.
// a finished result sits in the output register; a new item is accepted while it
// waits, and the result state stalls before overwriting it.
module can_frame_channel_mapper_core
  import canfcm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [EN_W-1:0]      cfg_wdata_i,      // enabled_channels
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // channel_index, entry_id, entry_id_mask, entry_byte_start, entry_byte_length,
  // entry_data_mask, entry_multiplier, entry_divisor, entry_offset, frame_id,
  // frame_data, zero fill
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [CMD_W-1:0]     s_axis_tuser_i,   // command
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [VAL_W-1:0]     m_axis_tdata_o,   // value
  output logic [STAT_W-1:0]    m_axis_tuser_o    // status
);

  fsm_e                state_q, state_d;
  logic [EN_W-1:0]     en_q;
  logic [CH_CNT_W-1:0] walk_q, walk_d;
  logic [CH_CNT_W-1:0] cnt_q, cnt_d;
  logic [ID_W-1:0]     fid_q, fid_d;
  logic [DATA_W-1:0]   fdata_q, fdata_d;
  logic [VAL_W-1:0]    acc_q, acc_d;
  status_e             res_status_q, res_status_d;
  logic [VAL_W-1:0]    res_value_q, res_value_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [VAL_W-1:0]    out_value_q, out_value_d;

  logic                s_acc;
  cmd_e                cmd;
  logic [CIDX_W-1:0]   in_idx;
  logic                in_range;
  logic [CH_IDX_W-1:0] in_addr;
  entry_t              in_entry;
  logic [CH_CNT_W-1:0] count;

  entry_t              ent;
  logic                tbl_we;
  logic                val_we;
  logic [VAL_W-1:0]    val_rdata;
  logic [CH_IDX_W-1:0] walk_addr;

  logic                hit;
  logic                bad_layout;
  logic [DATA_W-1:0]   shifted;
  logic [VAL_W-1:0]    len_mask;
  logic [VAL_W-1:0]    gathered;
  logic [VAL_W-1:0]    product;
  logic [VAL_W-1:0]    sum;

  logic                div_start;
  logic                div_done;
  logic [VAL_W-1:0]    div_quo;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd      = cmd_e'(s_axis_tuser_i);
  assign in_idx   = s_axis_tdata_i[OFF_IDX +: CIDX_W];
  assign in_range = 32'(in_idx) < 32'(CHANNELS);
  assign in_addr  = CH_IDX_W'(in_idx);

  assign in_entry.match_id    = s_axis_tdata_i[OFF_EID +: ID_W];
  assign in_entry.id_mask     = s_axis_tdata_i[OFF_EMSK +: ID_W];
  assign in_entry.byte_start  = s_axis_tdata_i[OFF_BST +: START_W];
  assign in_entry.byte_length = s_axis_tdata_i[OFF_BLEN +: LEN_W];
  assign in_entry.data_mask   = s_axis_tdata_i[OFF_DMSK +: VAL_W];
  assign in_entry.multiplier  = s_axis_tdata_i[OFF_MUL +: VAL_W];
  assign in_entry.divisor     = s_axis_tdata_i[OFF_DIV +: VAL_W];
  assign in_entry.offset      = s_axis_tdata_i[OFF_OFS +: VAL_W];

  // walk no more entries than the table has
  assign count = (32'(en_q) > 32'(CHANNELS)) ? CH_CNT_W'(CHANNELS) : CH_CNT_W'(en_q);

  assign walk_addr = CH_IDX_W'(walk_q);

  canfcm_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tbl_we_i    (tbl_we),
    .tbl_waddr_i (in_addr),
    .tbl_wdata_i (in_entry),
    .tbl_raddr_i (walk_addr),
    .tbl_rdata_o (ent),
    .val_we_i    (val_we),
    .val_waddr_i (walk_addr),
    .val_wdata_i (sum),
    .val_raddr_i (in_addr),
    .val_rdata_o (val_rdata)
  );

  assign div_start = (state_q == ST_DIV_GO);

  canfcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (ent.divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // entry evaluation
  assign hit        = (fid_q & ent.id_mask) == ent.match_id;
  assign bad_layout = (5'(ent.byte_start) + 5'(ent.byte_length)) > 5'(MAX_BYTES);
  assign shifted    = fdata_q >> {ent.byte_start, 3'b000};

  always_comb begin
    case (ent.byte_length)
      4'd1:    len_mask = 32'h0000_00FF;
      4'd2:    len_mask = 32'h0000_FFFF;
      4'd3:    len_mask = 32'h00FF_FFFF;
      4'd4:    len_mask = 32'hFFFF_FFFF;
      default: len_mask = '0;
    endcase
  end

  always_comb begin
    gathered = shifted[VAL_W-1:0] & len_mask;
    if (ent.data_mask != '0) begin
      gathered = gathered & ent.data_mask;
    end
  end

  assign product = acc_q * ent.multiplier;
  assign sum     = acc_q + ent.offset;

  always_comb begin
    state_d         = state_q;
    walk_d          = walk_q;
    cnt_d           = cnt_q;
    fid_d           = fid_q;
    fdata_d         = fdata_q;
    acc_d           = acc_q;
    res_status_d    = res_status_q;
    res_value_d     = res_value_q;
    out_valid_d     = out_valid_q;
    out_status_d    = out_status_q;
    out_value_d     = out_value_q;
    tbl_we          = 1'b0;
    val_we          = 1'b0;
    s_axis_tready_o = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          res_status_d = STAT_NONE;
          res_value_d  = '0;
          state_d      = ST_RESULT;
          case (cmd)
            CMD_LOAD: begin
              tbl_we = in_range;
            end
            CMD_FRAME: begin
              fid_d   = s_axis_tdata_i[OFF_FID +: ID_W];
              fdata_d = s_axis_tdata_i[OFF_FDAT +: DATA_W];
              walk_d  = '0;
              cnt_d   = count;
              state_d = ST_WALK;
            end
            CMD_READ: begin
              res_value_d = in_range ? val_rdata : '0;
            end
            default: begin
              res_value_d = '0;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_q >= cnt_q) begin
          state_d = ST_RESULT;
        end else if (hit) begin
          if (bad_layout) begin
            res_status_d = STAT_BAD;
            state_d      = ST_RESULT;
          end else begin
            acc_d   = gathered;
            state_d = ST_MUL;
          end
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      ST_MUL: begin
        if (ent.multiplier != '0) begin
          acc_d = product;
        end
        state_d = (ent.divisor != '0) ? ST_DIV_GO : ST_FINISH;
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          acc_d   = div_quo;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // a zero offset adds nothing, so the sum serves both cases
        val_we       = 1'b1;
        res_value_d  = sum;
        res_status_d = STAT_MATCH;
        walk_d       = walk_q + 1'b1;
        state_d      = ST_WALK;
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= '0;
      walk_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fid_q        <= fid_d;
    fdata_q      <= fdata_d;
    acc_q        <= acc_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_q <= CH_CNT_W'(CHANNELS))
    else $error("walk index beyond table");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_frame_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && cmd == CMD_FRAME) |=> state_q == ST_WALK)
    else $error("frame item did not start a walk");

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_we |-> walk_q < cnt_q)
    else $error("channel value stored past enabled count");

endmodule

// ===== rtl/core/canfcm_table.sv =====
module canfcm_table
  import canfcm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tbl_we_i,
  input  logic [CH_IDX_W-1:0] tbl_waddr_i,
  input  entry_t              tbl_wdata_i,
  input  logic [CH_IDX_W-1:0] tbl_raddr_i,
  output entry_t              tbl_rdata_o,
  input  logic                val_we_i,
  input  logic [CH_IDX_W-1:0] val_waddr_i,
  input  logic [VAL_W-1:0]    val_wdata_i,
  input  logic [CH_IDX_W-1:0] val_raddr_i,
  output logic [VAL_W-1:0]    val_rdata_o
);

  entry_t           tbl_q [CHANNELS];
  logic [VAL_W-1:0] val_q [CHANNELS];

  // entries hold nothing meaningful until loaded
  always_ff @(posedge clk_i) begin
    if (tbl_we_i) begin
      tbl_q[tbl_waddr_i] <= tbl_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        val_q[i] <= '0;
      end
    end else if (val_we_i) begin
      val_q[val_waddr_i] <= val_wdata_i;
    end
  end

  assign tbl_rdata_o = tbl_q[tbl_raddr_i];
  assign val_rdata_o = val_q[val_raddr_i];

endmodule

// ===== rtl/core/canfcm_div.sv =====
module canfcm_div
  import canfcm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] dividend_i,
  input  logic [VAL_W-1:0] divisor_i,
  output logic             done_o,
  output logic [VAL_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(VAL_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] quo_q, quo_d;
  logic [VAL_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;

  logic [VAL_W:0]   rem_sh;
  logic [VAL_W+1:0] diff;
  logic             ge;

  // restoring radix-2 step on magnitudes
  assign rem_sh = {rem_q, quo_q[VAL_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[VAL_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VAL_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i[VAL_W-1] ? (VAL_W'(0) - dividend_i) : dividend_i;
      dvs_d  = divisor_i[VAL_W-1] ? (VAL_W'(0) - divisor_i) : divisor_i;
      neg_d  = dividend_i[VAL_W-1] ^ divisor_i[VAL_W-1];
    end else if (busy_q) begin
      rem_d = ge ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
      quo_d = {quo_q[VAL_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // most negative over minus one wraps back to itself here
  assign quotient_o = neg_q ? (VAL_W'(0) - quo_q) : quo_q;
  assign done_o     = done_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == '0 && !start_i) |=> done_q)
    else $error("divider missed its done pulse");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

endmodule
